### rtl/core/legik_pkg.sv
// legik_pkg: shared types, constants and helper functions of the leg inverse kinematics block
// depends on nothing; used by every other file under rtl/core
package legik_pkg;

   localparam int COORD_W       = 16;
   localparam int LEN_W         = 15;
   localparam int ANGLE_W       = 8;
   localparam int OFFSET_W      = 8;
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int ROOT_W        = 32;
   localparam int RAD_W         = 2 * ROOT_W;
   localparam int REM_W         = ROOT_W + 2;
   localparam int H2_W          = 2 * COORD_W;
   localparam int DIFF_W        = H2_W + 2;
   localparam int EABS_W        = H2_W + 1;
   localparam int VEC_W         = H2_W + 4;
   localparam int ANG_W         = 26;
   localparam int ANG_FRAC      = 16;
   localparam int CMD_W         = ANG_W - ANG_FRAC + 2;
   localparam int NUM_VEC       = 4;
   localparam int ADDR_W        = 5;
   localparam int CSR_DATA_W    = 32;

   localparam int VEC_PHI   = 0;
   localparam int VEC_ALPHA = 1;
   localparam int VEC_BETA  = 2;
   localparam int VEC_GAMMA = 3;

   localparam logic [LEN_W-1:0]          LEN_RESET = LEN_W'(1280);
   localparam logic signed [ANG_W-1:0]   DEG90     = ANG_W'(90 << ANG_FRAC);
   localparam logic signed [ANG_W-1:0]   DEG180    = ANG_W'(180 << ANG_FRAC);
   localparam logic signed [CMD_W-1:0]   CMD_MAX   = CMD_W'(180);
   localparam logic [ANGLE_W-1:0]        ANGLE_MAX = ANGLE_W'(180);

   typedef enum logic [2:0] {
      REG_UPPER_LENGTH = 3'd0,
      REG_LOWER_LENGTH = 3'd1,
      REG_MIRROR_MODE  = 3'd2,
      REG_ROLL_OFFSET  = 3'd3,
      REG_PITCH_OFFSET = 3'd4,
      REG_KNEE_OFFSET  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
   } req_data_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] knee_angle;
      logic [ANGLE_W-1:0] shoulder_pitch_angle;
      logic [ANGLE_W-1:0] shoulder_roll_angle;
      logic               unreachable;
      logic               saturated;
   } rsp_data_type;

   typedef struct packed {
      logic                     valid;
      logic                     unreach;
      logic [RAD_W-1:0]         rad;
      logic [REM_W-1:0]         rem;
      logic [ROOT_W-1:0]        root;
      logic [DIFF_W-1:0]        d;
      logic [EABS_W-1:0]        e_abs;
      logic [COORD_W-1:0]       x;
      logic [COORD_W-1:0]       y;
      logic [COORD_W-1:0]       z;
   } sqrt_slice_type;

   typedef struct packed {
      logic [VEC_W-1:0] vx;
      logic [VEC_W-1:0] vy;
      logic [ANG_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic                       valid;
      logic                       unreach;
      logic [NUM_VEC-1:0]         zero;
      vec_type [NUM_VEC-1:0]      vec;
   } cordic_slice_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               clamped;
   } servo_type;

   // atan(2^-i) in degrees, 16 fractional bits
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] v;
      unique case (idx)
         0:  v = ANG_W'(2949120);
         1:  v = ANG_W'(1740967);
         2:  v = ANG_W'(919879);
         3:  v = ANG_W'(466945);
         4:  v = ANG_W'(234379);
         5:  v = ANG_W'(117304);
         6:  v = ANG_W'(58666);
         7:  v = ANG_W'(29335);
         8:  v = ANG_W'(14668);
         9:  v = ANG_W'(7334);
         10: v = ANG_W'(3667);
         11: v = ANG_W'(1833);
         12: v = ANG_W'(917);
         13: v = ANG_W'(458);
         14: v = ANG_W'(229);
         15: v = ANG_W'(115);
         16: v = ANG_W'(57);
         17: v = ANG_W'(29);
         18: v = ANG_W'(14);
         19: v = ANG_W'(7);
         20: v = ANG_W'(4);
         21: v = ANG_W'(2);
         22: v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // quadrant pre-rotation by +-90 degrees ahead of the vectoring stages
   function automatic vec_type prerotate(input logic signed [VEC_W-1:0] num,
                                         input logic signed [VEC_W-1:0] den);
      vec_type v;
      v.vx = den;
      v.vy = num;
      v.z  = '0;
      if (den < 0) begin
         if (num >= 0) begin
            v.vx = num;
            v.vy = VEC_W'(-den);
            v.z  = DEG90;
         end else begin
            v.vx = VEC_W'(-num);
            v.vy = den;
            v.z  = ANG_W'(-DEG90);
         end
      end
      return v;
   endfunction

   // round to whole degrees half away from zero, add offset, clamp to 0..180
   function automatic servo_type finish_angle(input logic signed [ANG_W-1:0] ang,
                                              input logic signed [OFFSET_W-1:0] off);
      logic [ANG_W-1:0]               mag;
      logic [ANG_W-ANG_FRAC-1:0]      whole;
      logic signed [CMD_W-1:0]        cmd;
      servo_type                      res;
      mag   = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
      whole = (ANG_W-ANG_FRAC)'((mag + ANG_W'(1 << (ANG_FRAC - 1))) >> ANG_FRAC);
      cmd   = ang[ANG_W-1] ? CMD_W'(-CMD_W'(whole)) : CMD_W'(whole);
      cmd   = cmd + CMD_W'(off);
      if (cmd < 0) begin
         res.angle   = '0;
         res.clamped = 1'b1;
      end else if (cmd > CMD_MAX) begin
         res.angle   = ANGLE_MAX;
         res.clamped = 1'b1;
      end else begin
         res.angle   = ANGLE_W'(cmd);
         res.clamped = 1'b0;
      end
      return res;
   endfunction

endpackage

### rtl/core/leg_inverse_kinematics_3dof_top.sv
// leg_inverse_kinematics_3dof_top: three-joint leg solver, squares, root chain, cordic chain
// depends on legik_pkg, legik_sqrt_cell, legik_cordic_cell
//
// usage
//   req channel: one foot target (x, y, z) per transaction, valid/stall handshake
//   rsp channel: knee, shoulder pitch and shoulder roll commands in degrees plus
//     unreachable and saturated flags, one rsp transaction per req transaction,
//     in order
//   csr port: apb-style, six registers at byte addresses 0..20, pready tied high;
//     write only while the pipeline is empty
//   latency: 39 + CORDIC_STAGES cycles from req to rsp (55 by default): four
//     cycles of squares and products, 32 root cells, one pre-rotation register,
//     the cordic cells, one angle register and the output register
//   throughput: one transaction per cycle; the root and cordic cells are
//     fully pipelined
//   reset: clears all valid bits and loads the register defaults
//   stall: when rsp_stall holds a waiting result, the pipeline keeps moving
//     as long as its last stage is empty; once full, req_stall is raised
module leg_inverse_kinematics_3dof_top #(
   parameter int CORDIC_STAGES = legik_pkg::CORDIC_STAGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  legik_pkg::req_data_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output legik_pkg::rsp_data_type             rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [legik_pkg::ADDR_W-1:0]        paddr,
   input  logic [legik_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [legik_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   localparam int CW = legik_pkg::COORD_W;
   localparam int LW = legik_pkg::LEN_W;
   localparam int HW = legik_pkg::H2_W;
   localparam int DW = legik_pkg::CSR_DATA_W;
   localparam int OW = legik_pkg::OFFSET_W;
   localparam int VW = legik_pkg::VEC_W;
   localparam int AW = legik_pkg::ANG_W;
   localparam int NS = legik_pkg::ROOT_W;

   // registers
   logic [LW-1:0]          upper_length_ff;
   logic [LW-1:0]          lower_length_ff;
   logic                   mirror_mode_ff;
   logic signed [OW-1:0]   roll_offset_ff;
   logic signed [OW-1:0]   pitch_offset_ff;
   logic signed [OW-1:0]   knee_offset_ff;
   logic                   csr_write;
   legik_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = legik_pkg::reg_index_type'(paddr[legik_pkg::ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_length_ff <= legik_pkg::LEN_RESET;
         lower_length_ff <= legik_pkg::LEN_RESET;
         mirror_mode_ff  <= 1'b0;
         roll_offset_ff  <= '0;
         pitch_offset_ff <= '0;
         knee_offset_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            legik_pkg::REG_UPPER_LENGTH: upper_length_ff <= pwdata[LW-1:0];
            legik_pkg::REG_LOWER_LENGTH: lower_length_ff <= pwdata[LW-1:0];
            legik_pkg::REG_MIRROR_MODE:  mirror_mode_ff  <= pwdata[0];
            legik_pkg::REG_ROLL_OFFSET:  roll_offset_ff  <= pwdata[OW-1:0];
            legik_pkg::REG_PITCH_OFFSET: pitch_offset_ff <= pwdata[OW-1:0];
            legik_pkg::REG_KNEE_OFFSET:  knee_offset_ff  <= pwdata[OW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         legik_pkg::REG_UPPER_LENGTH: prdata = DW'(upper_length_ff);
         legik_pkg::REG_LOWER_LENGTH: prdata = DW'(lower_length_ff);
         legik_pkg::REG_MIRROR_MODE:  prdata = DW'(mirror_mode_ff);
         legik_pkg::REG_ROLL_OFFSET:  prdata = {{(DW-OW){1'b0}}, roll_offset_ff};
         legik_pkg::REG_PITCH_OFFSET: prdata = {{(DW-OW){1'b0}}, pitch_offset_ff};
         legik_pkg::REG_KNEE_OFFSET:  prdata = {{(DW-OW){1'b0}}, knee_offset_ff};
         default:                     prdata = '0;
      endcase
   end

   // flow control
   logic rsp_valid_ff;
   legik_pkg::rsp_data_type rsp_data_ff;
   legik_pkg::rsp_data_type rsp_data_in;
   logic f1_valid_ff;
   logic out_take;
   logic adv;

   assign out_take  = !rsp_valid_ff || !rsp_stall;
   assign adv       = out_take || !f1_valid_ff;
   assign req_stall = !adv;

   // stage 1: squares, leg length sum and difference
   logic [CW-1:0]        ax_c;
   logic [CW-1:0]        ay_c;
   logic                 p1_valid_ff;
   logic [HW-1:0]        p1_axx_ff;
   logic [HW-1:0]        p1_ayy_ff;
   logic [2*LW-1:0]      p1_uu_ff;
   logic [2*LW-1:0]      p1_ll_ff;
   logic [LW:0]          p1_sum_ff;
   logic [LW-1:0]        p1_diff_ff;
   logic [CW-1:0]        p1_x_ff;
   logic [CW-1:0]        p1_y_ff;
   logic [CW-1:0]        p1_z_ff;

   assign ax_c = req_data.target_x[CW-1] ? CW'(-req_data.target_x) : CW'(req_data.target_x);
   assign ay_c = req_data.target_y[CW-1] ? CW'(-req_data.target_y) : CW'(req_data.target_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= req_valid;
         p1_axx_ff   <= HW'(ax_c) * HW'(ax_c);
         p1_ayy_ff   <= HW'(ay_c) * HW'(ay_c);
         p1_uu_ff    <= (2*LW)'(upper_length_ff) * (2*LW)'(upper_length_ff);
         p1_ll_ff    <= (2*LW)'(lower_length_ff) * (2*LW)'(lower_length_ff);
         p1_sum_ff   <= (LW+1)'(upper_length_ff) + (LW+1)'(lower_length_ff);
         p1_diff_ff  <= (upper_length_ff > lower_length_ff) ?
                        LW'(upper_length_ff - lower_length_ff) :
                        LW'(lower_length_ff - upper_length_ff);
         p1_x_ff     <= req_data.target_x;
         p1_y_ff     <= req_data.target_y;
         p1_z_ff     <= req_data.target_z;
      end
   end

   // stage 2: reach squared and reach bounds
   logic                 p2_valid_ff;
   logic [HW-1:0]        p2_h2_ff;
   logic [HW-1:0]        p2_sumsq_ff;
   logic [2*LW-1:0]      p2_diffsq_ff;
   logic [2*LW-1:0]      p2_uu_ff;
   logic [2*LW-1:0]      p2_ll_ff;
   logic [CW-1:0]        p2_x_ff;
   logic [CW-1:0]        p2_y_ff;
   logic [CW-1:0]        p2_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff  <= p1_valid_ff;
         p2_h2_ff     <= p1_axx_ff + p1_ayy_ff;
         p2_sumsq_ff  <= HW'(p1_sum_ff) * HW'(p1_sum_ff);
         p2_diffsq_ff <= (2*LW)'(p1_diff_ff) * (2*LW)'(p1_diff_ff);
         p2_uu_ff     <= p1_uu_ff;
         p2_ll_ff     <= p1_ll_ff;
         p2_x_ff      <= p1_x_ff;
         p2_y_ff      <= p1_y_ff;
         p2_z_ff      <= p1_z_ff;
      end
   end

   // stage 3: reach check, law of cosines terms
   logic [legik_pkg::DIFF_W-1:0]  d_c;
   logic [legik_pkg::DIFF_W-1:0]  e_c;
   logic                          p3_valid_ff;
   logic                          p3_unreach_ff;
   logic [legik_pkg::DIFF_W-1:0]  p3_d_ff;
   logic [legik_pkg::EABS_W-1:0]  p3_eabs_ff;
   logic [HW-1:0]                 p3_a_ff;
   logic [HW-1:0]                 p3_b_ff;
   logic [CW-1:0]                 p3_x_ff;
   logic [CW-1:0]                 p3_y_ff;
   logic [CW-1:0]                 p3_z_ff;

   assign d_c = legik_pkg::DIFF_W'(p2_uu_ff) + legik_pkg::DIFF_W'(p2_ll_ff)
              - legik_pkg::DIFF_W'(p2_h2_ff);
   assign e_c = legik_pkg::DIFF_W'(p2_uu_ff) + legik_pkg::DIFF_W'(p2_h2_ff)
              - legik_pkg::DIFF_W'(p2_ll_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff   <= p2_valid_ff;
         p3_unreach_ff <= (p2_h2_ff == '0) || (p2_h2_ff < HW'(p2_diffsq_ff))
                          || (p2_h2_ff > p2_sumsq_ff);
         p3_d_ff       <= d_c;
         p3_eabs_ff    <= e_c[legik_pkg::DIFF_W-1] ? legik_pkg::EABS_W'(-e_c)
                                                    : legik_pkg::EABS_W'(e_c);
         p3_a_ff       <= p2_h2_ff - HW'(p2_diffsq_ff);
         p3_b_ff       <= p2_sumsq_ff - p2_h2_ff;
         p3_x_ff       <= p2_x_ff;
         p3_y_ff       <= p2_y_ff;
         p3_z_ff       <= p2_z_ff;
      end
   end

   // stage 4: radicand (2UL)^2 - D^2 as a product of two differences
   logic                          p4_valid_ff;
   logic                          p4_unreach_ff;
   logic [legik_pkg::RAD_W-1:0]   p4_prod_ff;
   logic [legik_pkg::DIFF_W-1:0]  p4_d_ff;
   logic [legik_pkg::EABS_W-1:0]  p4_eabs_ff;
   logic [CW-1:0]                 p4_x_ff;
   logic [CW-1:0]                 p4_y_ff;
   logic [CW-1:0]                 p4_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (adv) begin
         p4_valid_ff   <= p3_valid_ff;
         p4_unreach_ff <= p3_unreach_ff;
         p4_prod_ff    <= legik_pkg::RAD_W'(p3_a_ff) * legik_pkg::RAD_W'(p3_b_ff);
         p4_d_ff       <= p3_d_ff;
         p4_eabs_ff    <= p3_eabs_ff;
         p4_x_ff       <= p3_x_ff;
         p4_y_ff       <= p3_y_ff;
         p4_z_ff       <= p3_z_ff;
      end
   end

   // square root chain
   legik_pkg::sqrt_slice_type sqrt_chain [0:NS];

   always_comb begin
      sqrt_chain[0].valid   = p4_valid_ff;
      sqrt_chain[0].unreach = p4_unreach_ff;
      sqrt_chain[0].rad     = p4_prod_ff;
      sqrt_chain[0].rem     = '0;
      sqrt_chain[0].root    = '0;
      sqrt_chain[0].d       = p4_d_ff;
      sqrt_chain[0].e_abs   = p4_eabs_ff;
      sqrt_chain[0].x       = p4_x_ff;
      sqrt_chain[0].y       = p4_y_ff;
      sqrt_chain[0].z       = p4_z_ff;
   end

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      legik_sqrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (adv),
         .up_slice   (sqrt_chain[k]),
         .down_slice (sqrt_chain[k+1])
      );
   end

   // pre-rotation register feeding the cordic chain
   legik_pkg::sqrt_slice_type   sq_tail;
   legik_pkg::cordic_slice_type cordic_head_ff;
   legik_pkg::cordic_slice_type cordic_head_in;
   logic signed [VW-1:0] s_v;
   logic signed [VW-1:0] d_v;
   logic signed [VW-1:0] e_v;
   logic signed [VW-1:0] x_v;
   logic signed [VW-1:0] y_v;
   logic signed [VW-1:0] z_v;

   assign sq_tail = sqrt_chain[NS];
   assign s_v = VW'(sq_tail.root);
   assign d_v = VW'($signed(sq_tail.d));
   assign e_v = VW'(sq_tail.e_abs);
   assign x_v = VW'($signed(sq_tail.x));
   assign y_v = VW'($signed(sq_tail.y));
   assign z_v = VW'($signed(sq_tail.z));

   always_comb begin
      cordic_head_in.valid   = sq_tail.valid;
      cordic_head_in.unreach = sq_tail.unreach;
      cordic_head_in.vec[legik_pkg::VEC_PHI]   = legik_pkg::prerotate(s_v, d_v);
      cordic_head_in.vec[legik_pkg::VEC_ALPHA] = legik_pkg::prerotate(s_v, e_v);
      cordic_head_in.vec[legik_pkg::VEC_BETA]  = legik_pkg::prerotate(x_v, y_v);
      cordic_head_in.vec[legik_pkg::VEC_GAMMA] = legik_pkg::prerotate(z_v, y_v);
      cordic_head_in.zero[legik_pkg::VEC_PHI]   = (s_v == '0) && (d_v == '0);
      cordic_head_in.zero[legik_pkg::VEC_ALPHA] = (s_v == '0) && (e_v == '0);
      cordic_head_in.zero[legik_pkg::VEC_BETA]  = (x_v == '0) && (y_v == '0);
      cordic_head_in.zero[legik_pkg::VEC_GAMMA] = (z_v == '0) && (y_v == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cordic_head_ff.valid <= 1'b0;
      end else if (adv) begin
         cordic_head_ff <= cordic_head_in;
      end
   end

   // cordic chain
   legik_pkg::cordic_slice_type cordic_chain [0:CORDIC_STAGES];

   assign cordic_chain[0] = cordic_head_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      legik_cordic_cell #(
         .SHIFT (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (adv),
         .up_slice   (cordic_chain[k]),
         .down_slice (cordic_chain[k+1])
      );
   end

   // joint angles
   legik_pkg::cordic_slice_type cd_tail;
   logic signed [AW-1:0] ang_c [legik_pkg::NUM_VEC];
   logic signed [AW-1:0] theta_c;
   logic signed [AW-1:0] knee_c;
   logic signed [AW-1:0] pitch_c;
   logic signed [AW-1:0] roll_c;
   logic                 f1_unreach_ff;
   logic signed [AW-1:0] f1_knee_ff;
   logic signed [AW-1:0] f1_pitch_ff;
   logic signed [AW-1:0] f1_roll_ff;

   assign cd_tail = cordic_chain[CORDIC_STAGES];

   always_comb begin
      for (int k = 0; k < legik_pkg::NUM_VEC; k++) begin
         ang_c[k] = cd_tail.zero[k] ? '0 : cd_tail.vec[k].z;
      end
      theta_c = ang_c[legik_pkg::VEC_ALPHA] - ang_c[legik_pkg::VEC_BETA];
      if (mirror_mode_ff) begin
         knee_c  = ang_c[legik_pkg::VEC_PHI];
         pitch_c = legik_pkg::DEG90 + theta_c;
         roll_c  = legik_pkg::DEG90 + ang_c[legik_pkg::VEC_GAMMA];
      end else begin
         knee_c  = legik_pkg::DEG180 - ang_c[legik_pkg::VEC_PHI];
         pitch_c = legik_pkg::DEG90 - theta_c;
         roll_c  = legik_pkg::DEG90 - ang_c[legik_pkg::VEC_GAMMA];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff   <= cd_tail.valid;
         f1_unreach_ff <= cd_tail.unreach;
         f1_knee_ff    <= knee_c;
         f1_pitch_ff   <= pitch_c;
         f1_roll_ff    <= roll_c;
      end
   end

   // servo commands and output register
   legik_pkg::servo_type knee_s;
   legik_pkg::servo_type pitch_s;
   legik_pkg::servo_type roll_s;

   always_comb begin
      knee_s  = legik_pkg::finish_angle(f1_knee_ff, knee_offset_ff);
      pitch_s = legik_pkg::finish_angle(f1_pitch_ff, pitch_offset_ff);
      roll_s  = legik_pkg::finish_angle(f1_roll_ff, roll_offset_ff);
      rsp_data_in.unreachable = f1_unreach_ff;
      if (f1_unreach_ff) begin
         rsp_data_in.knee_angle           = '0;
         rsp_data_in.shoulder_pitch_angle = '0;
         rsp_data_in.shoulder_roll_angle  = '0;
         rsp_data_in.saturated            = 1'b0;
      end else begin
         rsp_data_in.knee_angle           = knee_s.angle;
         rsp_data_in.shoulder_pitch_angle = pitch_s.angle;
         rsp_data_in.shoulder_roll_angle  = roll_s.angle;
         rsp_data_in.saturated            = knee_s.clamped | pitch_s.clamped
                                            | roll_s.clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= f1_valid_ff;
      end
      if (out_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/legik_sqrt_cell.sv
// legik_sqrt_cell: one result bit of the restoring integer square root chain
// depends on legik_pkg
module legik_sqrt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  legik_pkg::sqrt_slice_type  up_slice,
   output legik_pkg::sqrt_slice_type  down_slice
);

   legik_pkg::sqrt_slice_type slice_ff;
   legik_pkg::sqrt_slice_type slice_in;
   logic [legik_pkg::REM_W+1:0] rem_sh;
   logic [legik_pkg::REM_W+1:0] trial;

   always_comb begin
      slice_in     = up_slice;
      rem_sh       = {up_slice.rem, up_slice.rad[legik_pkg::RAD_W-1 -: 2]};
      trial        = {2'b00, up_slice.root, 2'b01};
      slice_in.rad = {up_slice.rad[legik_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         slice_in.rem  = legik_pkg::REM_W'(rem_sh - trial);
         slice_in.root = {up_slice.root[legik_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         slice_in.rem  = legik_pkg::REM_W'(rem_sh);
         slice_in.root = {up_slice.root[legik_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff.valid <= 1'b0;
      end else if (enable) begin
         slice_ff <= slice_in;
      end
   end

   assign down_slice = slice_ff;

endmodule

### rtl/core/legik_cordic_cell.sv
// legik_cordic_cell: one vectoring micro-rotation applied to all four angle vectors
// depends on legik_pkg
module legik_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  legik_pkg::cordic_slice_type  up_slice,
   output legik_pkg::cordic_slice_type  down_slice
);

   localparam logic signed [legik_pkg::ANG_W-1:0] STEP = legik_pkg::atan_entry(SHIFT);

   legik_pkg::cordic_slice_type slice_ff;
   legik_pkg::cordic_slice_type slice_in;

   always_comb begin
      logic signed [legik_pkg::VEC_W-1:0] vx;
      logic signed [legik_pkg::VEC_W-1:0] vy;
      logic signed [legik_pkg::ANG_W-1:0] zz;
      slice_in = up_slice;
      for (int k = 0; k < legik_pkg::NUM_VEC; k++) begin
         vx = up_slice.vec[k].vx;
         vy = up_slice.vec[k].vy;
         zz = up_slice.vec[k].z;
         if (vy > 0) begin
            slice_in.vec[k].vx = vx + (vy >>> SHIFT);
            slice_in.vec[k].vy = vy - (vx >>> SHIFT);
            slice_in.vec[k].z  = zz + STEP;
         end else begin
            slice_in.vec[k].vx = vx - (vy >>> SHIFT);
            slice_in.vec[k].vy = vy + (vx >>> SHIFT);
            slice_in.vec[k].z  = zz - STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff.valid <= 1'b0;
      end else if (enable) begin
         slice_ff <= slice_in;
      end
   end

   assign down_slice = slice_ff;

endmodule

### rtl/core/legik_checker.sv
// legik_checker: port-level assertions for the leg inverse kinematics top level
// depends on legik_pkg; bound to leg_inverse_kinematics_3dof_top below
module legik_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input legik_pkg::rsp_data_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unreachable |->
         rsp_data.knee_angle == '0 && rsp_data.shoulder_pitch_angle == '0
         && rsp_data.shoulder_roll_angle == '0 && !rsp_data.saturated)
      else $error("unreachable transaction carries nonzero angles");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.knee_angle <= legik_pkg::ANGLE_MAX
         && rsp_data.shoulder_pitch_angle <= legik_pkg::ANGLE_MAX
         && rsp_data.shoulder_roll_angle <= legik_pkg::ANGLE_MAX)
      else $error("angle above 180");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed");

endmodule

bind leg_inverse_kinematics_3dof_top legik_checker u_legik_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### verif/leg_inverse_kinematics_3dof_top_test.sv
// leg_inverse_kinematics_3dof_top_test: self-checking bench for the three-joint leg solver
// depends on legik_pkg and leg_inverse_kinematics_3dof_top; a local predictor checks every
// rsp transaction across several register settings, random idling and a long rsp hold-off
`timescale 1ns / 100ps

module leg_inverse_kinematics_3dof_top_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int ANG_FRAC       = legik_pkg::ANG_FRAC;
   localparam int ANGLE_W        = legik_pkg::ANGLE_W;
   localparam int ADDR_W         = legik_pkg::ADDR_W;
   localparam int CSR_DATA_W     = legik_pkg::CSR_DATA_W;
   localparam int COORD_W        = legik_pkg::COORD_W;
   localparam int LEN_W          = legik_pkg::LEN_W;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   legik_pkg::req_data_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   legik_pkg::rsp_data_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   leg_inverse_kinematics_3dof_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // register copies
   longint unsigned upper_len;
   longint unsigned lower_len;
   bit mirror_legs;
   longint roll_off;
   longint pitch_off;
   longint knee_off;

   legik_pkg::req_data_type pending_targets[$];
   legik_pkg::rsp_data_type expected_angles[$];
   int mismatches;
   int send_idle_pct;
   int recv_idle_pct;
   int accepted_targets;
   int hold_cycles;
   bit hold_done;
   int quiet_cycles;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic longint deg_atan2(input longint num, input longint den);
      longint vx;
      longint vy;
      longint za;
      longint nx;
      vx = den;
      vy = num;
      za = 0;
      if (num == 0 && den == 0) return 0;
      if (den < 0) begin
         if (num >= 0) begin
            vx = num; vy = -den; za = 90 <<< ANG_FRAC;
         end else begin
            vx = -num; vy = den; za = -(90 <<< ANG_FRAC);
         end
      end
      for (int i = 0; i < legik_pkg::CORDIC_STAGES; i++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> i);
            vy = vy - (vx >>> i);
            za = za + longint'(legik_pkg::atan_entry(i));
         end else begin
            nx = vx - (vy >>> i);
            vy = vy + (vx >>> i);
            za = za - longint'(legik_pkg::atan_entry(i));
         end
         vx = nx;
      end
      return za;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [ANGLE_W-1:0] servo_cmd(input longint ang, input longint off,
                                                   inout bit sat);
      longint mag;
      longint r;
      mag = ang < 0 ? -ang : ang;
      r = (mag + (1 <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
      if (ang < 0) r = -r;
      r = r + off;
      if (r < 0) begin
         sat = 1;
         return '0;
      end
      if (r > 180) begin
         sat = 1;
         return legik_pkg::ANGLE_MAX;
      end
      return r[ANGLE_W-1:0];
   endfunction

   function automatic legik_pkg::rsp_data_type solve_leg(input legik_pkg::req_data_type t);
      longint x;
      longint y;
      longint z;
      longint unsigned h2;
      longint unsigned diff;
      longint unsigned two_ul;
      longint unsigned s;
      longint d;
      longint e;
      longint phi;
      longint theta;
      longint gamma;
      longint knee;
      longint pitch;
      longint roll;
      bit sat;
      legik_pkg::rsp_data_type res;
      x = t.target_x;
      y = t.target_y;
      z = t.target_z;
      sat = 0;
      res = '0;
      h2 = longint'(x * x) + longint'(y * y);
      diff = upper_len > lower_len ? upper_len - lower_len : lower_len - upper_len;
      if (h2 == 0 || h2 < diff * diff ||
          h2 > (upper_len + lower_len) * (upper_len + lower_len)) begin
         res.unreachable = 1'b1;
         return res;
      end
      two_ul = 2 * upper_len * lower_len;
      d = longint'(upper_len * upper_len + lower_len * lower_len) - longint'(h2);
      e = longint'(upper_len * upper_len + h2) - longint'(lower_len * lower_len);
      s = floor_sqrt(longint'(unsigned'(longint'(two_ul) - d)) *
                     longint'(unsigned'(longint'(two_ul) + d)));
      phi = deg_atan2(longint'(s), d);
      theta = deg_atan2(longint'(s), e < 0 ? -e : e) - deg_atan2(x, y);
      gamma = deg_atan2(z, y);
      if (mirror_legs) begin
         knee = phi;
         pitch = (90 <<< ANG_FRAC) + theta;
         roll = (90 <<< ANG_FRAC) + gamma;
      end else begin
         knee = (180 <<< ANG_FRAC) - phi;
         pitch = (90 <<< ANG_FRAC) - theta;
         roll = (90 <<< ANG_FRAC) - gamma;
      end
      res.knee_angle = servo_cmd(knee, knee_off, sat);
      res.shoulder_pitch_angle = servo_cmd(pitch, pitch_off, sat);
      res.shoulder_roll_angle = servo_cmd(roll, roll_off, sat);
      res.saturated = sat;
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_angles.push_back(solve_leg(req_data));
            accepted_targets++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_targets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_targets.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      legik_pkg::rsp_data_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $error("rsp transaction with nothing expected");
               mismatches++;
            end else begin
               want = expected_angles.pop_front();
               if (rsp_data.knee_angle !== want.knee_angle) begin
                  $error("knee_angle expected %0d actual %0d",
                         want.knee_angle, rsp_data.knee_angle);
                  mismatches++;
               end
               if (rsp_data.shoulder_pitch_angle !== want.shoulder_pitch_angle) begin
                  $error("shoulder_pitch_angle expected %0d actual %0d",
                         want.shoulder_pitch_angle, rsp_data.shoulder_pitch_angle);
                  mismatches++;
               end
               if (rsp_data.shoulder_roll_angle !== want.shoulder_roll_angle) begin
                  $error("shoulder_roll_angle expected %0d actual %0d",
                         want.shoulder_roll_angle, rsp_data.shoulder_roll_angle);
                  mismatches++;
               end
               if (rsp_data.unreachable !== want.unreachable) begin
                  $error("unreachable expected %0d actual %0d",
                         want.unreachable, rsp_data.unreachable);
                  mismatches++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated expected %0d actual %0d",
                         want.saturated, rsp_data.saturated);
                  mismatches++;
               end
            end
         end
         // long hold-off so the pipeline fills and stalls req
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && accepted_targets >= 100) begin
            hold_done <= 1'b1;
            hold_cycles <= 150;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(99) < recv_idle_pct;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input legik_pkg::reg_index_type idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(4 * idx);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      unique case (idx)
         legik_pkg::REG_UPPER_LENGTH: upper_len = value[LEN_W-1:0];
         legik_pkg::REG_LOWER_LENGTH: lower_len = value[LEN_W-1:0];
         legik_pkg::REG_MIRROR_MODE:  mirror_legs = value[0];
         legik_pkg::REG_ROLL_OFFSET:  roll_off = longint'(signed'(value[7:0]));
         legik_pkg::REG_PITCH_OFFSET: pitch_off = longint'(signed'(value[7:0]));
         legik_pkg::REG_KNEE_OFFSET:  knee_off = longint'(signed'(value[7:0]));
         default: ;
      endcase
   endtask

   task automatic add_target(input longint x, input longint y, input longint z);
      legik_pkg::req_data_type t;
      t.target_x = x[COORD_W-1:0];
      t.target_y = y[COORD_W-1:0];
      t.target_z = z[COORD_W-1:0];
      pending_targets.push_back(t);
   endtask

   function automatic longint unsigned rand_upto(input longint unsigned span);
      longint unsigned r;
      r = {$urandom, $urandom};
      return r % (span + 1);
   endfunction

   // target whose planar reach lands inside the annulus the legs can cover
   task automatic add_reachable();
      longint unsigned reach;
      longint unsigned lo2;
      longint unsigned hi2;
      longint unsigned y2;
      longint x;
      longint y;
      reach = floor_sqrt((upper_len + lower_len) * (upper_len + lower_len));
      if (reach > 32767) reach = 32767;
      x = longint'(rand_upto(2 * reach)) - longint'(reach);
      hi2 = (upper_len + lower_len) * (upper_len + lower_len) - x * x;
      lo2 = (upper_len > lower_len ? upper_len - lower_len : lower_len - upper_len);
      lo2 = lo2 * lo2 > x * x ? lo2 * lo2 - x * x : 0;
      y2 = lo2 + rand_upto(hi2 - lo2);
      y = floor_sqrt(y2);
      if (y > 32767) y = 32767;
      if ($urandom_range(1)) y = -y;
      add_target(x, y, longint'($urandom_range(65535)) - 32768);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_targets.size() != 0 || req_valid || expected_angles.size() != 0);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] settings[4][6];
      settings = '{
         '{1, 1, 1, 0, 0, 0},
         '{32767, 32767, 0, 32'hA6, 32'h5A, 32'h80},
         '{20000, 9000, 1, 32'h7F, 32'h80, 32'd45},
         '{0, 3000, 0, 32'd10, 32'hF6, 32'h00}
      };
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatches = 0;
      accepted_targets = 0;
      hold_cycles = 0;
      hold_done = 0;
      quiet_cycles = 0;
      send_idle_pct = 17;
      recv_idle_pct = 68;
      upper_len = 1280;
      lower_len = 1280;
      mirror_legs = 0;
      roll_off = 0;
      pitch_off = 0;
      knee_off = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero reach, full reach, out of reach, coordinate extremes, negative y
      add_target(0, 0, 0);
      add_target(2560, 0, 0);
      add_target(0, 2560, 0);
      add_target(0, 2561, 0);
      add_target(0, 1, 0);
      add_target(0, -2000, 5);
      add_target(-32768, -32768, -32768);
      add_target(32767, 32767, 32767);
      add_target(100, 1500, -32768);
      add_target(-1500, -800, 32767);
      add_target(1000, 1000, 0);
      add_target(-2000, 300, -700);

      for (int p = 0; p < 5; p++) begin
         if (p > 0) begin
            wait_idle();
            repeat (60) @(posedge clock);
            for (int r = 0; r < 6; r++) begin
               csr_write(legik_pkg::reg_index_type'(r), settings[p-1][r]);
            end
         end
         if (p == 2) begin
            send_idle_pct = 68;
            recv_idle_pct = 17;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < 250; i++) begin
            if ($urandom_range(99) < 80) begin
               add_reachable();
            end else begin
               add_target(longint'($urandom_range(65535)) - 32768,
                          longint'($urandom_range(65535)) - 32768,
                          longint'($urandom_range(65535)) - 32768);
            end
         end
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_angles.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/legik_pkg.sv
rtl/core/legik_sqrt_cell.sv
rtl/core/legik_cordic_cell.sv
rtl/core/leg_inverse_kinematics_3dof_top.sv
rtl/core/legik_checker.sv
verif/leg_inverse_kinematics_3dof_top_test.sv
